/* src/rrq_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin ready queue package
// Shared sizes, command and error codes, and the per-cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rrq_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Port field widths.
    localparam int CMD_W      = 2;
    localparam int TAG_PORT_W = 16;
    localparam int COUNT_W    = 5;
    localparam int ERR_W      = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // Control for one cell of the tag chain.
    typedef struct packed {
        logic shift;   // take the tag of the right-hand neighbor
        logic load;    // take the newly added tag
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* src/rrq_cell.sv */
// ----------------------------------------------------------------------------
// Round-robin ready queue cell
// Holds one queue entry's tag; shifts in its neighbor's tag on a remove and
// captures a new tag on an add.
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_cell (
    input  wire                                i_clk,
    input  rrq_pkg::t_cell_ctrl                i_ctrl,
    input  wire [rrq_pkg::TAG_BITS-1:0]        i_next_tag,
    input  wire [rrq_pkg::TAG_BITS-1:0]        i_new_tag,
    output logic [rrq_pkg::TAG_BITS-1:0]       o_tag,
    output logic [rrq_pkg::TAG_BITS-1:0]       o_tag_next
);
    import rrq_pkg::*;

    logic [TAG_BITS-1:0] r_tag;
    logic [TAG_BITS-1:0] n_tag;

    // Next tag: a load wins, a shift takes the neighbor, otherwise hold.
    always_comb begin
        if (i_ctrl.load) begin
            n_tag = i_new_tag;
        end else if (i_ctrl.shift) begin
            n_tag = i_next_tag;
        end else begin
            n_tag = r_tag;
        end
    end

    // Tag storage needs no reset; an empty cell is never read.
    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    assign o_tag      = r_tag;
    assign o_tag_next = n_tag;

endmodule

`default_nettype wire

/* src/round_robin_ready_queue_core.sv */
// A result appears on the output register in the cycle after its item is
// accepted. Throughput: one item per cycle; the input stalls only while a
// finished result is held by a stalled output. The work per item is one
// update of the cell chain plus the cursor and count registers.
// Reset (synchronous, active low) empties the queue and the output register;
// the first item may be accepted as soon as reset is released.
// ----------------------------------------------------------------------------
// Round-robin ready queue core
// Packed chain of tag cells in insertion order with a cursor index; removes
// close the gap by shifting the cells behind the cursor one place down.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_ready_queue_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Command channel
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire [rrq_pkg::CMD_W-1:0]            i_cmd,
    input  wire [rrq_pkg::TAG_PORT_W-1:0]       i_item_tag,
    // Result channel
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [rrq_pkg::TAG_PORT_W-1:0]      o_cursor_tag,
    output logic                                o_cursor_valid,
    output logic [rrq_pkg::COUNT_W-1:0]         o_entry_count,
    output logic [rrq_pkg::ERR_W-1:0]           o_error_code
);
    import rrq_pkg::*;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    logic                do_add;
    logic                do_remove;
    logic                cursor_last;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [IDX_W-1:0]    r_cursor;
    logic [IDX_W-1:0]    n_cursor;
    logic [ERR_W-1:0]    n_err;

    logic [TAG_BITS-1:0] new_tag;
    logic [TAG_BITS-1:0] w_tag      [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] w_tag_next [QUEUE_DEPTH];
    t_cell_ctrl          w_ctrl     [QUEUE_DEPTH];

    logic                r_out_valid;
    logic [TAG_BITS-1:0] r_out_tag;
    logic                r_out_cvalid;
    logic [CNT_W-1:0]    r_out_count;
    logic [ERR_W-1:0]    r_out_err;

    // Handshake: the output register frees itself when taken; no item is
    // taken while reset is held.
    assign o_in_stall = !i_rst_n || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    assign is_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty    = (r_count == '0);
    assign cursor_last = ((CNT_W'(r_cursor) + CNT_W'(1)) == r_count);
    assign new_tag     = i_item_tag[TAG_BITS-1:0];

    assign do_add    = accept && (i_cmd == CMD_ADD) && !is_full;
    assign do_remove = accept && (i_cmd == CMD_REMOVE) && !is_empty;

    // Count, cursor and error code for the accepted command.
    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        n_err    = ERR_OK;
        case (i_cmd)
            CMD_ADD: begin
                if (is_full) begin
                    n_err = ERR_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (is_empty) begin
                    n_err = ERR_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    // The next entry slides under the cursor; wrap at the tail.
                    if (cursor_last) begin
                        n_cursor = '0;
                    end
                end
            end
            CMD_ADVANCE: begin
                if (!is_empty) begin
                    n_cursor = cursor_last ? '0 : r_cursor + IDX_W'(1);
                end
            end
            default: begin
                n_err = ERR_OK;
            end
        endcase
    end

    // Chain of tag cells, each fed by its right-hand neighbor; the last by itself.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [TAG_BITS-1:0] right_tag;

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_tag = w_tag[i];
        end else begin : g_mid
            assign right_tag = w_tag[i+1];
        end

        assign w_ctrl[i].load  = do_add && (r_count[IDX_W-1:0] == IDX_W'(i));
        assign w_ctrl[i].shift = do_remove && (IDX_W'(i) >= r_cursor);

        rrq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl[i]),
            .i_next_tag (right_tag),
            .i_new_tag  (new_tag),
            .o_tag      (w_tag[i]),
            .o_tag_next (w_tag_next[i])
        );
    end

    // Cursor and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else if (accept) begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload describes the queue after the step.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_cvalid <= (n_count != '0);
            r_out_tag    <= (n_count != '0) ? w_tag_next[n_cursor] : '0;
            r_out_count  <= n_count;
            r_out_err    <= n_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cursor_tag   = TAG_PORT_W'(r_out_tag);
    assign o_cursor_valid = r_out_cvalid;
    assign o_entry_count  = COUNT_W'(r_out_count);
    assign o_error_code   = r_out_err;

endmodule

`default_nettype wire

/* src/rrq_checker.sv */
// ----------------------------------------------------------------------------
// Round-robin ready queue checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    input  wire                                 o_in_stall,
    input  wire                                 o_out_valid,
    input  wire                                 i_out_stall,
    input  wire [rrq_pkg::TAG_PORT_W-1:0]       o_cursor_tag,
    input  wire                                 o_cursor_valid,
    input  wire [rrq_pkg::COUNT_W-1:0]          o_entry_count,
    input  wire [rrq_pkg::ERR_W-1:0]            o_error_code
);
    import rrq_pkg::*;

    // A stalled result holds its place and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_tag)
            && $stable(o_entry_count) && $stable(o_error_code))
        else $error("stalled result changed");

    // Every accepted item shows up as a result on the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted item produced no result");

    // The cursor is valid exactly when the queue holds entries.
    a_cvalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_valid == (o_entry_count != '0)))
        else $error("cursor valid disagrees with entry count");

    // An empty queue reports a zero tag, and the count stays in range.
    a_empty_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_valid || o_cursor_tag == '0)
            && (o_entry_count <= COUNT_W'(QUEUE_DEPTH)))
        else $error("bad empty tag or count out of range");

    // Errors only come with the matching queue fill.
    a_err_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_error_code == ERR_OK)
            || (o_error_code == ERR_EMPTY && o_entry_count == '0)
            || (o_error_code == ERR_FULL && o_entry_count == COUNT_W'(QUEUE_DEPTH)))
        else $error("error code inconsistent with entry count");

endmodule

bind round_robin_ready_queue_core rrq_checker u_rrq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_cursor_tag   (o_cursor_tag),
    .o_cursor_valid (o_cursor_valid),
    .o_entry_count  (o_entry_count),
    .o_error_code   (o_error_code)
);

`default_nettype wire

/* tb/tb_round_robin_ready_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin ready queue core testbench
// Drives add, remove, advance and unused commands into the core and keeps a
// behavioral ring of tags with a cursor to predict each result. Every result
// is checked field by field against the oldest pending prediction. Both sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_round_robin_ready_queue_core;

    import rrq_pkg::*;

    // The unused command code, which the core treats as a no-op.
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam int IDLE_PCT       = 22;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1420;

    // Queue view carried by one result item.
    typedef struct packed {
        logic [TAG_PORT_W-1:0] cursor_tag;
        logic                  cursor_valid;
        logic [COUNT_W-1:0]    entry_count;
        logic [ERR_W-1:0]      error_code;
    } t_queue_view;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd = CMD_NOP;
    logic [TAG_PORT_W-1:0] i_item_tag = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [TAG_PORT_W-1:0] o_cursor_tag;
    logic                  o_cursor_valid;
    logic [COUNT_W-1:0]    o_entry_count;
    logic [ERR_W-1:0]      o_error_code;

    // Predicted ring in queue order, with the cursor as a position in it.
    logic [TAG_PORT_W-1:0] ring_tags[$];
    int                    cursor_pos = 0;
    t_queue_view           pending_views[$];

    int mismatch_count = 0;
    bit no_idle = 1'b0;
    int hold_reqs = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    round_robin_ready_queue_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_item_tag     (i_item_tag),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_tag   (o_cursor_tag),
        .o_cursor_valid (o_cursor_valid),
        .o_entry_count  (o_entry_count),
        .o_error_code   (o_error_code)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one command to the predicted ring and return the queue view after it.
    function automatic t_queue_view apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [TAG_PORT_W-1:0] tag);
        t_queue_view view;
        view.error_code = ERR_OK;
        case (cmd)
            CMD_ADD: begin
                if (ring_tags.size() >= QUEUE_DEPTH) begin
                    view.error_code = ERR_FULL;
                end else begin
                    if (ring_tags.size() == 0)
                        cursor_pos = 0;
                    ring_tags.push_back(tag);
                end
            end
            CMD_REMOVE: begin
                if (ring_tags.size() == 0) begin
                    view.error_code = ERR_EMPTY;
                end else begin
                    ring_tags.delete(cursor_pos);
                    // Removing the tail wraps the cursor around to the head.
                    if (cursor_pos >= ring_tags.size())
                        cursor_pos = 0;
                end
            end
            CMD_ADVANCE: begin
                if (ring_tags.size() != 0)
                    cursor_pos = (cursor_pos + 1) % ring_tags.size();
            end
            default: begin
            end
        endcase
        view.cursor_valid = (ring_tags.size() != 0);
        view.cursor_tag   = view.cursor_valid ? ring_tags[cursor_pos] : '0;
        view.entry_count  = COUNT_W'(ring_tags.size());
        return view;
    endfunction

    task automatic report_mismatch(input string field, input int expected_val,
                                   input int actual_val);
        $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t",
                 field, expected_val, actual_val, $realtime);
        mismatch_count++;
    endtask

    // Offer one item, idling first at random, and record its prediction once taken.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [TAG_PORT_W-1:0] tag);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_item_tag <= tag;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_views.push_back(apply_command(cmd, tag));
    endtask

    // Result side: check each accepted result, then choose the next stall value.
    always @(posedge i_clk) begin
        t_queue_view want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_views.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    mismatch_count++;
                end else begin
                    want = pending_views.pop_front();
                    if (o_cursor_tag !== want.cursor_tag)
                        report_mismatch("cursor_tag", want.cursor_tag, o_cursor_tag);
                    if (o_cursor_valid !== want.cursor_valid)
                        report_mismatch("cursor_valid", want.cursor_valid, o_cursor_valid);
                    if (o_entry_count !== want.entry_count)
                        report_mismatch("entry_count", want.entry_count, o_entry_count);
                    if (o_error_code !== want.error_code)
                        report_mismatch("error_code", want.error_code, o_error_code);
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (hold_reqs != holds_served) begin
                holds_served = holds_served + 1;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Commands on an empty queue: remove flags an error, advance and no-op do not.
    task automatic test_empty_queue();
        send_command(CMD_REMOVE, 16'h1234);
        send_command(CMD_ADVANCE, 16'hFFFF);
        send_command(CMD_NOP, 16'h0000);
    endtask

    // Cursor movement: advance onto the tail, remove it and wrap to the head.
    task automatic test_cursor_wrap();
        send_command(CMD_ADD, 16'hA5A5);
        send_command(CMD_ADD, 16'h5A5A);
        send_command(CMD_ADVANCE, 16'h0000);
        send_command(CMD_REMOVE, 16'h0000);
        send_command(CMD_REMOVE, 16'h0000);
    endtask

    // Fill the queue with extreme and mixed tags, then add once more to overflow.
    task automatic test_fill_and_overflow();
        send_command(CMD_ADD, 16'h0000);
        send_command(CMD_ADD, 16'hFFFF);
        for (int k = 2; k < QUEUE_DEPTH; k++)
            send_command(CMD_ADD, 16'($urandom_range(16'hFFFF)));
        send_command(CMD_ADD, 16'hBEEF);
    endtask

    // Random command mix; the add share shifts every hundred items so the queue
    // swings between empty and full.
    task automatic random_command(input int add_pct);
        int roll;
        int tag_roll;
        logic [CMD_W-1:0] cmd;
        logic [TAG_PORT_W-1:0] tag;
        roll = $urandom_range(99);
        if (roll < 3)
            cmd = CMD_NOP;
        else if (roll < 3 + add_pct)
            cmd = CMD_ADD;
        else if ($urandom_range(9) < 4)
            cmd = CMD_REMOVE;
        else
            cmd = CMD_ADVANCE;
        tag_roll = $urandom_range(9);
        if (tag_roll == 0)
            tag = '0;
        else if (tag_roll == 1)
            tag = '1;
        else
            tag = 16'($urandom_range(16'hFFFF));
        send_command(cmd, tag);
    endtask

    // The result side holds off while items keep coming, so the core fills and
    // stalls its input.
    task automatic test_output_backpressure();
        no_idle = 1'b1;
        hold_reqs <= hold_reqs + 1;
        for (int k = 0; k < 30; k++)
            random_command(50);
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic(input int n_items);
        int add_pct;
        add_pct = 50;
        for (int k = 0; k < n_items; k++) begin
            if (k % 100 == 0) begin
                case ($urandom_range(2))
                    0: add_pct = 20;
                    1: add_pct = 50;
                    default: add_pct = 80;
                endcase
                // One long stretch runs with no idling on either side.
                no_idle = (k / 100 == 5);
            end
            random_command(add_pct);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_cursor_wrap();
        test_fill_and_overflow();
        test_output_backpressure();
        test_random_traffic(RANDOM_ITEMS);
        i_in_valid <= 1'b0;

        // Drain every pending result, then let the core run on idle before the verdict.
        while (pending_views.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
